// File: sv/hpt_pkg.sv
package hpt_pkg;

  localparam int FRAC = 16;
  localparam int CW = 32;
  localparam int PW = 2 * CW;
  localparam int SW = PW + 2;
  localparam int NUM_REGS = 8;
  localparam int IDXW = $clog2(NUM_REGS);
  localparam int RW = 2 * CW;

  // divider: one radix-2 step per bit, DIV_STEP bits per stage
  localparam int DIVW_RAW = CW + FRAC;
  localparam int DIV_STEP = 2;
  localparam int DIV_STAGES = (DIVW_RAW + DIV_STEP - 1) / DIV_STEP;
  localparam int DIVW = DIV_STAGES * DIV_STEP;

  // 3 MAC stages, 1 prep stage, divider stages, 1 clamp stage
  localparam int LATENCY = DIV_STAGES + 5;

  localparam logic [CW-1:0] ONE_FX = CW'(1) << FRAC;

  typedef enum logic [IDXW-1:0] {
    REG_ROW0_COLS01 = 3'd0,
    REG_ROW0_COLS23 = 3'd1,
    REG_ROW1_COLS01 = 3'd2,
    REG_ROW1_COLS23 = 3'd3,
    REG_ROW2_COLS01 = 3'd4,
    REG_ROW2_COLS23 = 3'd5,
    REG_ROW3_COLS01 = 3'd6,
    REG_ROW3_COLS23 = 3'd7
  } cfg_reg_e;

  typedef logic [3:0][3:0][CW-1:0] mat_t;

  typedef struct packed {
    logic              valid;
    logic              sat;
    logic [2:0][CW-1:0] v;
    logic [CW-1:0]     w;
  } row_res_t;

  typedef struct packed {
    logic              valid;
    logic              div;
    logic              sat;
    logic [2:0][CW-1:0] v;
  } item_meta_t;

  function automatic logic [RW-1:0] cfg_reset(cfg_reg_e r);
    logic [RW-1:0] val;
    unique case (r)
      REG_ROW0_COLS01: val = RW'(ONE_FX);
      REG_ROW1_COLS01: val = RW'(ONE_FX) << CW;
      REG_ROW2_COLS23: val = RW'(ONE_FX);
      REG_ROW3_COLS23: val = RW'(ONE_FX);
      default:         val = '0;
    endcase
    return val;
  endfunction

endpackage

// File: sv/homogeneous_point_transform_top.sv
// Homogeneous 4x4 point transform with perspective divide, Q16.16.
// Input: pulse start with point_x/y/z_i; a point is taken on every edge where
// start is high and busy is low. busy is never raised, so one point per clock.
// Output: valid_o is high for one cycle with out_x/y/z_o, divided_o and
// saturated_o. The receiver cannot stall; results leave in input order.
// Pipeline: three stages of multiply, sum and rescale/clamp, one prep
// stage (magnitudes, w test), a long divider of two quotient bits per
// stage per lane, one clamp stage.
// Throughput: one point per cycle, set by the fully pipelined divider lanes.
// Matrix: eight 64-bit registers written through cfg_we_i/cfg_idx_i/
// cfg_wdata_i, coefficient pair low half first. Write only while the
// pipeline is empty. Reset loads the default matrix and empties the
// pipeline; no results appear until new points are started.
module homogeneous_point_transform_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [31:0]            point_x_i,
  input  logic signed [31:0]            point_y_i,
  input  logic signed [31:0]            point_z_i,
  input  logic                          cfg_we_i,
  input  logic [hpt_pkg::IDXW-1:0]      cfg_idx_i,
  input  logic [hpt_pkg::RW-1:0]        cfg_wdata_i,
  output logic                          valid_o,
  output logic signed [31:0]            out_x_o,
  output logic signed [31:0]            out_y_o,
  output logic signed [31:0]            out_z_o,
  output logic                          divided_o,
  output logic                          saturated_o
);

  localparam int N = hpt_pkg::DIV_STAGES;
  localparam int C = hpt_pkg::CW;

  logic [hpt_pkg::RW-1:0]      cfg_q [hpt_pkg::NUM_REGS];
  hpt_pkg::mat_t               mat;
  hpt_pkg::row_res_t           res;
  hpt_pkg::item_meta_t         prep_d, prep_q;
  hpt_pkg::item_meta_t         dl_q [N+1];
  logic [2:0][hpt_pkg::DIVW-1:0] num_d, num_q;
  logic [2:0]                  neg_d, neg_q;
  logic [C-1:0]                wabs_d, wabs_q;
  logic [2:0][C-1:0]           quo;
  logic [2:0]                  qsat;
  logic [2:0][C-1:0]           vabs;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < hpt_pkg::NUM_REGS; i++) begin
        cfg_q[i] <= hpt_pkg::cfg_reset(hpt_pkg::cfg_reg_e'(i));
      end
    end else if (cfg_we_i) begin
      cfg_q[cfg_idx_i] <= cfg_wdata_i;
    end
  end

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        mat[r][c] = cfg_q[2*r + c/2][C*(c%2) +: C];
      end
    end
  end

  hpt_mac u_mac (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (start & ~busy),
    .point_i    ({point_z_i, point_y_i, point_x_i}),
    .mat_i      (mat),
    .res_o      (res)
  );

  // w test and operand magnitudes for the dividers; flags only ride with a transaction
  always_comb begin
    prep_d.valid = res.valid;
    prep_d.sat   = res.valid && res.sat;
    prep_d.v     = res.v;
    prep_d.div   = res.valid && (res.w != hpt_pkg::ONE_FX) && (res.w != '0);
    wabs_d       = res.w[C-1] ? C'(-res.w) : res.w;
    for (int i = 0; i < 3; i++) begin
      vabs[i]  = res.v[i][C-1] ? C'(-res.v[i]) : res.v[i];
      num_d[i] = hpt_pkg::DIVW'({vabs[i], {hpt_pkg::FRAC{1'b0}}});
      neg_d[i] = res.v[i][C-1] ^ res.w[C-1];
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    neg_q  <= neg_d;
    wabs_q <= wabs_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prep_q <= '0;
      for (int s = 0; s <= N; s++) begin
        dl_q[s] <= '0;
      end
    end else begin
      prep_q  <= prep_d;
      dl_q[0] <= prep_q;
      for (int s = 1; s <= N; s++) begin
        dl_q[s] <= dl_q[s-1];
      end
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_div
    hpt_div u_div (
      .clk_i (clk_i),
      .num_i (num_q[g]),
      .dsr_i (wabs_q),
      .neg_i (neg_q[g]),
      .q_o   (quo[g]),
      .sat_o (qsat[g])
    );
  end

  assign valid_o     = dl_q[N].valid;
  assign divided_o   = dl_q[N].div;
  assign saturated_o = dl_q[N].sat | (dl_q[N].div & (|qsat));
  assign out_x_o     = dl_q[N].div ? quo[0] : dl_q[N].v[0];
  assign out_y_o     = dl_q[N].div ? quo[1] : dl_q[N].v[1];
  assign out_z_o     = dl_q[N].div ? quo[2] : dl_q[N].v[2];

endmodule

// File: sv/hpt_mac.sv
module hpt_mac (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic [2:0][hpt_pkg::CW-1:0]     point_i,
  input  hpt_pkg::mat_t                   mat_i,
  output hpt_pkg::row_res_t               res_o
);

  logic signed [hpt_pkg::PW-1:0] prod_d [4][3];
  logic signed [hpt_pkg::PW-1:0] prod_q [4][3];
  logic signed [hpt_pkg::SW-1:0] sum_d [4];
  logic signed [hpt_pkg::SW-1:0] sum_q [4];
  logic [3:0][hpt_pkg::CW-1:0]   row_d;
  logic [3:0]                    sat_d;
  logic                          v1_q, v2_q;
  hpt_pkg::row_res_t             res_d, res_q;

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod_d[r][c] = $signed(mat_i[r][c]) * $signed(point_i[c]);
      end
    end
  end

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      sum_d[r] = hpt_pkg::SW'(prod_q[r][0]) + hpt_pkg::SW'(prod_q[r][1])
               + hpt_pkg::SW'(prod_q[r][2]);
    end
  end

  // floor rescale, add translation, clamp to 32 bits
  always_comb begin
    logic signed [hpt_pkg::SW-1:0] sh;
    logic signed [hpt_pkg::SW:0]   t;
    for (int r = 0; r < 4; r++) begin
      sh = sum_q[r] >>> hpt_pkg::FRAC;
      t = (hpt_pkg::SW+1)'(sh) + (hpt_pkg::SW+1)'($signed(mat_i[r][3]));
      sat_d[r] = !((&t[hpt_pkg::SW:hpt_pkg::CW-1]) | ~(|t[hpt_pkg::SW:hpt_pkg::CW-1]));
      if (sat_d[r]) begin
        row_d[r] = t[hpt_pkg::SW] ? {1'b1, {(hpt_pkg::CW-1){1'b0}}}
                                  : {1'b0, {(hpt_pkg::CW-1){1'b1}}};
      end else begin
        row_d[r] = t[hpt_pkg::CW-1:0];
      end
    end
    res_d.valid = v2_q;
    res_d.sat   = |sat_d;
    res_d.v     = row_d[2:0];
    res_d.w     = row_d[3];
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    sum_q  <= sum_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      res_q <= '0;
    end else begin
      v1_q  <= in_valid_i;
      v2_q  <= v1_q;
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

// File: sv/hpt_div.sv
module hpt_div (
  input  logic                       clk_i,
  input  logic [hpt_pkg::DIVW-1:0]   num_i,
  input  logic [hpt_pkg::CW-1:0]     dsr_i,
  input  logic                       neg_i,
  output logic [hpt_pkg::CW-1:0]     q_o,
  output logic                       sat_o
);

  localparam int N = hpt_pkg::DIV_STAGES;
  localparam int W = hpt_pkg::DIVW;
  localparam int C = hpt_pkg::CW;

  typedef struct packed {
    logic [C-1:0] rem;
    logic [W-1:0] num;
  } div_st_t;

  div_st_t      st_d [N];
  div_st_t      st_q [N];
  logic [C-1:0] dsr_q [N];
  logic         neg_q [N];
  logic [C-1:0] q_d, q_q;
  logic         sat_d, sat_q;

  // restoring steps; quotient bits shift in as dividend bits shift out
  function automatic div_st_t div_step(div_st_t s, logic [C-1:0] d);
    div_st_t o;
    logic [C:0] t;
    o = s;
    for (int k = 0; k < hpt_pkg::DIV_STEP; k++) begin
      t = {o.rem, o.num[W-1]};
      o.num = {o.num[W-2:0], 1'b0};
      if (t >= {1'b0, d}) begin
        o.rem = C'(t - {1'b0, d});
        o.num[0] = 1'b1;
      end else begin
        o.rem = t[C-1:0];
      end
    end
    return o;
  endfunction

  always_comb begin
    st_d[0] = div_step('{rem: '0, num: num_i}, dsr_i);
    for (int s = 1; s < N; s++) begin
      st_d[s] = div_step(st_q[s-1], dsr_q[s-1]);
    end
  end

  always_comb begin
    logic [W-1:0] mag;
    mag = st_q[N-1].num;
    if (neg_q[N-1]) begin
      sat_d = (|mag[W-1:C]) | (mag[C-1] & (|mag[C-2:0]));
      q_d   = sat_d ? {1'b1, {(C-1){1'b0}}} : C'(-mag[C-1:0]);
    end else begin
      sat_d = |mag[W-1:C-1];
      q_d   = sat_d ? {1'b0, {(C-1){1'b1}}} : mag[C-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    st_q[0]  <= st_d[0];
    dsr_q[0] <= dsr_i;
    neg_q[0] <= neg_i;
    for (int s = 1; s < N; s++) begin
      st_q[s]  <= st_d[s];
      dsr_q[s] <= dsr_q[s-1];
      neg_q[s] <= neg_q[s-1];
    end
    q_q   <= q_d;
    sat_q <= sat_d;
  end

  assign q_o   = q_q;
  assign sat_o = sat_q;

endmodule

// File: sv/hpt_checker.sv
module hpt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        valid_o,
  input logic        divided_o,
  input logic        saturated_o
);

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised");

  a_result_has_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start && !busy, hpt_pkg::LATENCY))
    else $error("result without a transaction");

  a_reset_empties: assert property (@(posedge clk_i) !rst_ni |=> !valid_o)
    else $error("result just after reset");

  a_flags_with_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_o |-> !divided_o && !saturated_o)
    else $error("flags without result");

endmodule

bind homogeneous_point_transform_top hpt_checker u_hpt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .valid_o     (valid_o),
  .divided_o   (divided_o),
  .saturated_o (saturated_o)
);
